// ----- hw/rtl/pida_pkg.sv -----
// ----------------------------------------------------------------------------
// pida_pkg
// Shared constants, request and status codes, and the cell control bundle of
// the positional insert/delete list.
// ----------------------------------------------------------------------------
package pida_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int ENTRY_BITS_DEF = 32;

  // pointer width that covers every supported capacity and its count
  localparam int PTR_W    = 9;

  localparam int REQ_W    = 2;
  localparam int POS_W    = 8;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int ELEM_W   = 32;
  localparam int EIDX_W   = 4;
  localparam int COUNT_W  = 5;

  typedef logic [REQ_W-1:0]    req_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam req_t REQ_INSERT  = 2'd0;
  localparam req_t REQ_REMOVE  = 2'd1;
  localparam req_t REQ_MATCH   = 2'd2;
  localparam req_t REQ_READOUT = 2'd3;

  localparam status_t ST_DONE     = 3'd0;
  localparam status_t ST_NULL     = 3'd1;
  localparam status_t ST_BADPOS   = 3'd2;
  localparam status_t ST_FULL     = 3'd3;
  localparam status_t ST_NOTFOUND = 3'd4;
  localparam status_t ST_EMPTY    = 3'd5;

  typedef logic [1:0] cell_op_t;

  localparam cell_op_t CELL_HOLD = 2'd0;
  localparam cell_op_t CELL_INS  = 2'd1;
  localparam cell_op_t CELL_DEL  = 2'd2;
  localparam cell_op_t CELL_ROT  = 2'd3;

  typedef struct packed {
    cell_op_t         op;
    logic [PTR_W-1:0] pos;
    logic [PTR_W-1:0] last;
  } cell_ctl_t;

endpackage

// ----- hw/rtl/pida_if.sv -----
// ----------------------------------------------------------------------------
// pida_if
// Valid/ready channels for requests into and results out of the list block.
// ----------------------------------------------------------------------------
interface pida_req_if;
  import pida_pkg::*;

  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [POS_W-1:0]    position;
  logic [VALUE_W-1:0]  value;

  modport source (output valid, req_type, position, value, input ready);
  modport sink   (input valid, req_type, position, value, output ready);
endinterface

interface pida_rsp_if;
  import pida_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ELEM_W-1:0]   element;
  logic [EIDX_W-1:0]   element_index;
  logic [COUNT_W-1:0]  count;
  logic                last;

  modport source (output valid, status, element, element_index, count, last, input ready);
  modport sink   (input valid, status, element, element_index, count, last, output ready);
endinterface

// ----- hw/rtl/pida_cell.sv -----
// ----------------------------------------------------------------------------
// pida_cell
// One list slot: holds an entry and takes a neighbor's entry, the new word or
// the head entry as the broadcast cell command says.
// ----------------------------------------------------------------------------
module pida_cell #(
  parameter int ENTRY_BITS = pida_pkg::ENTRY_BITS_DEF,
  parameter int IDX        = 0
) (
  input  logic                clk,
  input  pida_pkg::cell_ctl_t ctl,
  input  logic [ENTRY_BITS-1:0] val,
  input  logic [ENTRY_BITS-1:0] left_data,
  input  logic [ENTRY_BITS-1:0] right_data,
  input  logic [ENTRY_BITS-1:0] head_data,
  output logic [ENTRY_BITS-1:0] data
);
  import pida_pkg::*;

  localparam logic [PTR_W-1:0] MY_IDX = PTR_W'(IDX);

  logic [ENTRY_BITS-1:0] data_r;
  logic [ENTRY_BITS-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      CELL_INS: begin
        if (MY_IDX > ctl.pos) begin
          data_nxt = left_data;
        end else if (MY_IDX == ctl.pos) begin
          data_nxt = val;
        end
      end
      CELL_DEL: begin
        if (MY_IDX >= ctl.pos) begin
          data_nxt = right_data;
        end
      end
      CELL_ROT: begin
        if (MY_IDX < ctl.last) begin
          data_nxt = right_data;
        end else if (MY_IDX == ctl.last) begin
          data_nxt = head_data;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// ----- hw/rtl/pida_chain.sv -----
// ----------------------------------------------------------------------------
// pida_chain
// Row of list cells; slot zero is the head, seen by the controller and fed
// back to every cell for rotation.
// ----------------------------------------------------------------------------
module pida_chain #(
  parameter int CAPACITY   = pida_pkg::CAPACITY_DEF,
  parameter int ENTRY_BITS = pida_pkg::ENTRY_BITS_DEF
) (
  input  logic                  clk,
  input  pida_pkg::cell_ctl_t   ctl,
  input  logic [ENTRY_BITS-1:0] val,
  output logic [ENTRY_BITS-1:0] head
);
  import pida_pkg::*;

  // slot g sits at ext[g+1]; both ends are tied to zero
  logic [ENTRY_BITS-1:0] ext [CAPACITY+2];

  assign ext[0]          = '0;
  assign ext[CAPACITY+1] = '0;
  assign head            = ext[1];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    pida_cell #(
      .ENTRY_BITS (ENTRY_BITS),
      .IDX        (g)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .val        (val),
      .left_data  (ext[g]),
      .right_data (ext[g+2]),
      .head_data  (ext[1]),
      .data       (ext[g+1])
    );
  end

endmodule

// ----- hw/rtl/positional_insert_delete_array.sv -----
// ----------------------------------------------------------------------------
// positional_insert_delete_array
// Ordered list of entry words kept in a row of shifting cells.
//
// Requests arrive on in_req (valid/ready) and results leave on out_rsp
// through one output register; a request is taken once the previous result
// has left, or in the same cycle as the receiver takes it. Insert and remove
// at a position shift the whole row together. Their single result is
// valid in the cycle after the request is taken, and the next request may
// follow at once.
// Remove by value rotates the row through the head cell, one entry per
// cycle, once over every entry, drops the first match on the way, and then
// shows its result. Read out also rotates through the head, giving one
// result per cycle while the receiver takes them, count results in all; the
// last one carries last = 1. No request is taken during a rotation.
// A stalled receiver holds the output register and freezes a read out; the
// scan of a remove by value runs on. Reset clears the count and the control;
// entry words are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
module positional_insert_delete_array #(
  parameter int CAPACITY   = pida_pkg::CAPACITY_DEF,
  parameter int ENTRY_BITS = pida_pkg::ENTRY_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  pida_req_if.sink   in_req,
  pida_rsp_if.source out_rsp
);
  import pida_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [1:0] S_DUMP = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [IDX_W-1:0]      step_r, step_nxt;
  logic [IDX_W-1:0]      scan_end_r, scan_end_nxt;
  logic                  found_r, found_nxt;
  logic [ENTRY_BITS-1:0] key_r, key_nxt;

  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r;
  logic [ELEM_W-1:0]     out_element_r;
  logic [EIDX_W-1:0]     out_index_r;
  logic [COUNT_W-1:0]    out_count_r;
  logic                  out_last_r;

  logic                  can_emit;
  logic                  in_acc;
  logic                  emit;
  status_t               res_status;
  logic [ELEM_W-1:0]     res_elem;
  logic [EIDX_W-1:0]     res_index;
  logic [CNT_W-1:0]      res_count;
  logic                  res_last;

  logic [ENTRY_BITS-1:0] val_e;
  logic [ENTRY_BITS-1:0] head;
  logic [PTR_W-1:0]      pos_p;
  logic [PTR_W-1:0]      cnt_p;
  logic [IDX_W-1:0]      cnt_last;
  cell_ctl_t             ctl;

  assign can_emit = !out_valid_r || out_rsp.ready;
  assign in_req.ready = (state_r == S_IDLE) && can_emit;
  assign in_acc   = in_req.valid && in_req.ready;

  assign val_e    = ENTRY_BITS'({{ENTRY_BITS{1'b0}}, in_req.value});
  assign pos_p    = PTR_W'(in_req.position);
  assign cnt_p    = PTR_W'(cnt_r);
  assign cnt_last = IDX_W'(cnt_r - CNT_W'(1));

  pida_chain #(
    .CAPACITY   (CAPACITY),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_chain (
    .clk  (clk),
    .ctl  (ctl),
    .val  (val_e),
    .head (head)
  );

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    step_nxt     = step_r;
    scan_end_nxt = scan_end_r;
    found_nxt    = found_r;
    key_nxt      = key_r;
    emit         = 1'b0;
    res_status   = ST_DONE;
    res_elem     = '0;
    res_index    = '0;
    res_count    = cnt_r;
    res_last     = 1'b1;
    ctl          = '{op: CELL_HOLD, pos: '0, last: '0};
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_req.req_type)
            REQ_INSERT: begin
              emit = 1'b1;
              if (val_e == '0) begin
                res_status = ST_NULL;
              end else if (cnt_r == CNT_W'(CAPACITY)) begin
                res_status = ST_FULL;
              end else begin
                ctl.op    = CELL_INS;
                ctl.pos   = (pos_p > cnt_p) ? cnt_p : pos_p;
                cnt_nxt   = cnt_r + CNT_W'(1);
                res_count = cnt_r + CNT_W'(1);
              end
            end
            REQ_REMOVE: begin
              emit = 1'b1;
              if (pos_p >= cnt_p) begin
                res_status = ST_BADPOS;
              end else begin
                ctl.op    = CELL_DEL;
                ctl.pos   = pos_p;
                cnt_nxt   = cnt_r - CNT_W'(1);
                res_count = cnt_r - CNT_W'(1);
              end
            end
            REQ_MATCH: begin
              if (val_e == '0) begin
                emit       = 1'b1;
                res_status = ST_NULL;
              end else if (cnt_r == '0) begin
                emit       = 1'b1;
                res_status = ST_NOTFOUND;
              end else begin
                state_nxt    = S_SCAN;
                step_nxt     = '0;
                found_nxt    = 1'b0;
                key_nxt      = val_e;
                scan_end_nxt = cnt_last;
              end
            end
            default: begin
              if (cnt_r == '0) begin
                emit       = 1'b1;
                res_status = ST_EMPTY;
              end else begin
                state_nxt = S_DUMP;
                step_nxt  = '0;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        if (!found_r && (head == key_r)) begin
          ctl.op    = CELL_DEL;
          ctl.pos   = '0;
          cnt_nxt   = cnt_r - CNT_W'(1);
          found_nxt = 1'b1;
        end else begin
          ctl.op   = CELL_ROT;
          ctl.last = cnt_p - PTR_W'(1);
        end
        step_nxt = step_r + IDX_W'(1);
        if (step_r == scan_end_r) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (can_emit) begin
          emit       = 1'b1;
          res_status = found_r ? ST_DONE : ST_NOTFOUND;
          state_nxt  = S_IDLE;
        end
      end
      S_DUMP: begin
        res_last = (step_r == cnt_last);
        if (can_emit) begin
          emit      = 1'b1;
          ctl.op    = CELL_ROT;
          ctl.last  = cnt_p - PTR_W'(1);
          res_elem  = ELEM_W'({{ELEM_W{1'b0}}, head});
          res_index = EIDX_W'(step_r);
          step_nxt  = step_r + IDX_W'(1);
          if (res_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r     <= step_nxt;
    scan_end_r <= scan_end_nxt;
    found_r    <= found_nxt;
    key_r      <= key_nxt;
    if (emit) begin
      out_status_r  <= res_status;
      out_element_r <= res_elem;
      out_index_r   <= res_index;
      out_count_r   <= COUNT_W'(res_count);
      out_last_r    <= res_last;
    end
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.status        = out_status_r;
  assign out_rsp.element       = out_element_r;
  assign out_rsp.element_index = out_index_r;
  assign out_rsp.count         = out_count_r;
  assign out_rsp.last          = out_last_r;

endmodule

// ----- hw/rtl/pida_checker.sv -----
// ----------------------------------------------------------------------------
// pida_checker
// Port-level checks on the result channel of the list block.
// ----------------------------------------------------------------------------
module pida_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [pida_pkg::STATUS_W-1:0]    out_status,
  input logic [pida_pkg::ELEM_W-1:0]      out_element,
  input logic [pida_pkg::EIDX_W-1:0]      out_element_index,
  input logic [pida_pkg::COUNT_W-1:0]     out_count,
  input logic                             out_last
);
  import pida_pkg::*;

  // only a read out spreads over several results
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_DONE) |-> out_last)
    else $error("non-done status without last");

  a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |->
      (out_element == '0) && (out_count == '0) && (out_element_index == '0))
    else $error("empty result carries data");

  // held entries are never null
  a_readout_nonnull: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> (out_element != '0) && (out_status == ST_DONE))
    else $error("read out emitted a null entry");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_element) && $stable(out_element_index) &&
      $stable(out_count) && $stable(out_last))
    else $error("result changed under stall");

endmodule

bind positional_insert_delete_array pida_checker u_pida_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_rsp.valid),
  .out_ready         (out_rsp.ready),
  .out_status        (out_rsp.status),
  .out_element       (out_rsp.element),
  .out_element_index (out_rsp.element_index),
  .out_count         (out_rsp.count),
  .out_last          (out_rsp.last)
);

// ----- tb/pida_list_checker.sv -----
// ----------------------------------------------------------------------------
// pida_list_checker
// Watches the request and result channels of the positional insert/delete
// list, keeps a shadow copy of the list, predicts every result of each
// accepted request and compares the results in order, field by field.
// ----------------------------------------------------------------------------
module pida_list_checker
  import pida_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               req_valid,
  input  logic               req_ready,
  input  req_t               req_type,
  input  logic [POS_W-1:0]   req_position,
  input  logic [VALUE_W-1:0] req_value,
  input  logic               rsp_valid,
  input  logic               rsp_ready,
  input  status_t            rsp_status,
  input  logic [ELEM_W-1:0]  rsp_element,
  input  logic [EIDX_W-1:0]  rsp_element_index,
  input  logic [COUNT_W-1:0] rsp_count,
  input  logic               rsp_last,
  output int                 errors,
  output int                 pending,
  output int                 requests_seen,
  output int                 results_seen
);

  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    status_t            status;
    logic [ELEM_W-1:0]  element;
    logic [EIDX_W-1:0]  element_index;
    logic [COUNT_W-1:0] count;
    logic               last;
  } list_rsp_t;

  logic [ELEM_W-1:0] shadow_list [CAPACITY];
  int                shadow_len = 0;
  list_rsp_t         expected_rsps [$];
  int                err_cnt = 0;
  int                req_cnt = 0;
  int                rsp_cnt = 0;

  initial begin
    errors        = 0;
    pending       = 0;
    requests_seen = 0;
    results_seen  = 0;
  end

  function automatic list_rsp_t make_rsp(status_t st, logic [ELEM_W-1:0] elem, int idx,
                                         int cnt, logic lst);
    list_rsp_t r;
    r.status        = st;
    r.element       = elem;
    r.element_index = EIDX_W'(idx);
    r.count         = COUNT_W'(cnt);
    r.last          = lst;
    return r;
  endfunction

  function automatic string rsp_text(list_rsp_t r);
    return $sformatf("status=%0d element=%h index=%0d count=%0d last=%0b",
                     r.status, r.element, r.element_index, r.count, r.last);
  endfunction

  task automatic drop_entry(input int at);
    for (int i = at; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
    shadow_len--;
  endtask

  task automatic predict_request(input req_t rt, input logic [POS_W-1:0] pos,
                                 input logic [VALUE_W-1:0] val);
    status_t st;
    int      at;
    int      hit;
    st = ST_DONE;
    case (rt)
      REQ_INSERT: begin
        if (val == '0) st = ST_NULL;
        else if (shadow_len >= CAPACITY) st = ST_FULL;
        else begin
          // beyond the tail means append
          at = (int'(pos) > shadow_len) ? shadow_len : int'(pos);
          for (int i = shadow_len; i > at; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[at] = val;
          shadow_len++;
        end
      end
      REQ_REMOVE: begin
        if (int'(pos) >= shadow_len) st = ST_BADPOS;
        else drop_entry(int'(pos));
      end
      REQ_MATCH: begin
        if (val == '0) st = ST_NULL;
        else begin
          hit = -1;
          for (int i = 0; i < shadow_len && hit < 0; i++) begin
            if (shadow_list[i] == val) hit = i;
          end
          if (hit < 0) st = ST_NOTFOUND;
          else drop_entry(hit);
        end
      end
      default: begin
        if (shadow_len == 0) st = ST_EMPTY;
        else begin
          for (int i = 0; i < shadow_len; i++) begin
            expected_rsps.push_back(make_rsp(ST_DONE, shadow_list[i], i, shadow_len,
                                             i == shadow_len - 1));
          end
          return;
        end
      end
    endcase
    expected_rsps.push_back(make_rsp(st, '0, 0, shadow_len, 1'b1));
  endtask

  always @(posedge clk) begin
    list_rsp_t got;
    list_rsp_t want;
    if (!rst_n) begin
      shadow_len = 0;
      expected_rsps.delete();
    end else begin
      if (req_valid && req_ready) begin
        predict_request(req_type, req_position, req_value);
        req_cnt++;
      end
      if (rsp_valid && rsp_ready) begin
        got.status        = rsp_status;
        got.element       = rsp_element;
        got.element_index = rsp_element_index;
        got.count         = rsp_count;
        got.last          = rsp_last;
        rsp_cnt++;
        if (expected_rsps.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("%0t: unexpected result, expected none, actual %s",
                     $time, rsp_text(got));
        end else begin
          want = expected_rsps.pop_front();
          if (got.status !== want.status || got.element !== want.element ||
              got.element_index !== want.element_index || got.count !== want.count ||
              got.last !== want.last) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
              $display("%0t: mismatch, expected %s, actual %s",
                       $time, rsp_text(want), rsp_text(got));
          end
        end
      end
    end
    errors        <= err_cnt;
    pending       <= expected_rsps.size();
    requests_seen <= req_cnt;
    results_seen  <= rsp_cnt;
  end

endmodule

// ----- tb/positional_insert_delete_array_tb.sv -----
// ----------------------------------------------------------------------------
// positional_insert_delete_array_tb
// Drives requests into the list block with random gaps and random result
// stalls: a directed run through empty, null, bad position, miss and full
// cases, then random phases that grow, churn and shrink the list. The
// checker beside the block predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module positional_insert_delete_array_tb;
  import pida_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int MAX_IDLE    = 14;
  localparam int PHASE_ITEMS = 75;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic quiet = 1'b0;
  int   cycle_cnt;
  int   errors;
  int   pending;
  int   requests_seen;
  int   results_seen;

  pida_req_if req_ch ();
  pida_rsp_if rsp_ch ();

  positional_insert_delete_array u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  pida_list_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req_ch.valid),
    .req_ready         (req_ch.ready),
    .req_type          (req_ch.req_type),
    .req_position      (req_ch.position),
    .req_value         (req_ch.value),
    .rsp_valid         (rsp_ch.valid),
    .rsp_ready         (rsp_ch.ready),
    .rsp_status        (rsp_ch.status),
    .rsp_element       (rsp_ch.element),
    .rsp_element_index (rsp_ch.element_index),
    .rsp_count         (rsp_ch.count),
    .rsp_last          (rsp_ch.last),
    .errors            (errors),
    .pending           (pending),
    .requests_seen     (requests_seen),
    .results_seen      (results_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int draw_idle();
    return quiet ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  task automatic send_req(input req_t rt, input logic [POS_W-1:0] pos,
                          input logic [VALUE_W-1:0] val);
    int gap;
    gap = draw_idle();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= rt;
    req_ch.position <= pos;
    req_ch.value    <= val;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic run_phase(input int n, input int p_ins, input int p_rem, input int p_match);
    int               r;
    req_t             rt;
    logic [POS_W-1:0] pos;
    logic [VALUE_W-1:0] val;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < p_ins) rt = REQ_INSERT;
      else if (r < p_ins + p_rem) rt = REQ_REMOVE;
      else if (r < p_ins + p_rem + p_match) rt = REQ_MATCH;
      else rt = REQ_READOUT;
      // positions mostly near the list size, sometimes anywhere
      if ($urandom_range(0, 7) == 0) pos = POS_W'($urandom_range(0, 255));
      else pos = POS_W'($urandom_range(0, 17));
      // small value pool so matches hit, some wide words and some nulls
      case ($urandom_range(0, 9))
        0:       val = '0;
        1, 2:    val = $urandom;
        default: val = VALUE_W'($urandom_range(1, 8));
      endcase
      send_req(rt, pos, val);
    end
  endtask

  initial begin
    int stall;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_idle();
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results still expected", cycle_cnt, pending);
    $display("FAIL positional_insert_delete_array");
    $finish;
  end

  initial begin
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= REQ_INSERT;
    req_ch.position <= '0;
    req_ch.value    <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty list, null words, tail append, head and middle insert
    send_req(REQ_READOUT, 8'd0, 32'd0);
    send_req(REQ_REMOVE, 8'd0, 32'd0);
    send_req(REQ_INSERT, 8'd0, 32'd0);
    send_req(REQ_MATCH, 8'd3, 32'd0);
    send_req(REQ_INSERT, 8'd255, 32'hFFFF_FFFF);
    send_req(REQ_INSERT, 8'd0, 32'd1);
    send_req(REQ_INSERT, 8'd1, 32'h8000_0000);
    send_req(REQ_READOUT, 8'd255, 32'hFFFF_FFFF);
    send_req(REQ_REMOVE, 8'd3, 32'd0);
    send_req(REQ_MATCH, 8'd0, 32'd1);
    // fill up, then one insert too many
    for (int i = 0; i < 15; i++) send_req(REQ_INSERT, POS_W'($urandom_range(0, 20)), 32'(i + 2));
    send_req(REQ_READOUT, 8'd0, 32'd0);
    send_req(REQ_MATCH, 8'd0, 32'h7777_7777);
    send_req(REQ_REMOVE, 8'd15, 32'd0);
    send_req(REQ_REMOVE, 8'd0, 32'd0);

    run_phase(PHASE_ITEMS, 60, 10, 15);
    quiet = 1'b1;
    run_phase(PHASE_ITEMS, 35, 25, 25);
    quiet = 1'b0;
    run_phase(PHASE_ITEMS, 15, 45, 25);
    run_phase(PHASE_ITEMS, 50, 15, 15);
    quiet = 1'b1;
    run_phase(PHASE_ITEMS, 30, 30, 30);
    quiet = 1'b0;
    run_phase(PHASE_ITEMS, 40, 20, 20);

    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (24) @(posedge clk);

    $display("covered %0d requests and %0d results: inserts, removes at position,",
             requests_seen, results_seen);
    $display("removes by value and read outs, with null, full, empty, miss and bad position");
    if (errors == 0) begin
      $display("PASS positional_insert_delete_array");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL positional_insert_delete_array");
    end
    $finish;
  end

endmodule

// ----- positional_insert_delete_array.f -----
hw/rtl/pida_pkg.sv
hw/rtl/pida_if.sv
hw/rtl/pida_cell.sv
hw/rtl/pida_chain.sv
hw/rtl/positional_insert_delete_array.sv
hw/rtl/pida_checker.sv
tb/pida_list_checker.sv
tb/positional_insert_delete_array_tb.sv
